// ===== rtl/idt_pkg.sv =====
package idt_pkg;

  // Count width default and field widths
  localparam int COUNT_BITS_DEF = 31;
  localparam int CMD_W          = 8;
  localparam int VAL_W          = 31;
  localparam int LVL_W          = 7;
  localparam int REQ_W          = 2;
  localparam int IN_DATA_W      = 56;
  localparam int OUT_DATA_W     = 40;

  // Request kinds (slave tuser)
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CMD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SETUP = 2'd2;

  // Timer command codes
  localparam logic [CMD_W-1:0] CMD_STOP        = 8'h20;
  localparam logic [CMD_W-1:0] CMD_LOAD        = 8'h39;
  localparam logic [CMD_W-1:0] CMD_LOAD_RELOAD = 8'h3d;
  localparam logic [CMD_W-1:0] CMD_READ        = 8'h40;
  localparam logic [CMD_W-1:0] CMD_READ_STOP   = 8'h60;
  localparam logic [CMD_W-1:0] CMD_READ_LOAD   = 8'h79;

  // Load of zero with CMD_LOAD means this count
  localparam logic [15:0] DEFAULT_COUNT = 16'd26042;
  localparam logic [LVL_W-1:0] RESET_LEVEL = 7'h5f;

  // first member lands in the top bits: read_data ends up lowest
  typedef struct packed {
    logic [LVL_W-1:0] irq_level;
    logic             irq_request;
    logic [VAL_W-1:0] read_data;
  } result_t;

endpackage

// ===== rtl/interval_down_timer.sv =====
// Interval down timer. Each transfer on the slave side is one item: a base
// time tick (38.4 us of system time), a timer command, or an interrupt setup,
// selected by s_tuser. Every accepted item yields exactly one result on the
// master side: the remaining count for read commands (0 while the timer is
// idle), and a one-item interrupt request with its level when a tick makes
// the count run out while the interrupt is enabled and not active. Loads of
// zero expire on the next counting tick; command 0x39 with a zero count
// loads 26042 instead. With cfg_wr_data set, the count moves once every two
// ticks. Command 0x3d reloads a nonzero count on expiry while the interrupt
// is enabled. Throughput is one item per clock: all state updates in the
// cycle of the transfer, and the result lands in an output register backed
// by a one-entry skid buffer, so s_tready only drops when both are full.
// Write the configuration register only while no result is outstanding.
module interval_down_timer #(
  parameter int COUNT_BITS = idt_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration: double_resolution
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data,
  // slave side
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tdata, low bit up: command[7:0], count_value[38:8], setup_enable[39],
  // int_level[46:40], int_enabled[47], int_active[48], zero[55:49]
  input  logic [idt_pkg::IN_DATA_W-1:0]   s_tdata,
  // tuser: req_type[1:0]
  input  logic [idt_pkg::REQ_W-1:0]       s_tuser,
  // master side
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // tdata, low bit up: read_data[30:0], irq_request[31], irq_level[38:32],
  // zero[39]
  output logic [idt_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import idt_pkg::*;

  // unpacked input fields
  logic [CMD_W-1:0]      command;
  logic [VAL_W-1:0]      count_value;
  logic                  setup_enable;
  logic [LVL_W-1:0]      int_level;
  logic                  int_enabled;
  logic                  int_active;
  logic [COUNT_BITS-1:0] cnt_in;

  assign command      = s_tdata[7:0];
  assign count_value  = s_tdata[38:8];
  assign setup_enable = s_tdata[39];
  assign int_level    = s_tdata[46:40];
  assign int_enabled  = s_tdata[47];
  assign int_active   = s_tdata[48];
  // count masked (or widened) to the counter width
  assign cnt_in       = COUNT_BITS'(count_value);

  // timer state
  logic                  double_resolution;
  logic [COUNT_BITS-1:0] remaining_count, remaining_count_next;
  logic                  counting, counting_next;
  logic                  pulse_enable, pulse_enable_next;
  logic [CMD_W-1:0]      last_command, last_command_next;
  logic [COUNT_BITS-1:0] reload_value, reload_value_next;
  logic [LVL_W-1:0]      level_store, level_store_next;
  logic                  prescale_phase, prescale_phase_next;

  // output register and skid entry
  result_t res;
  result_t out_reg;
  result_t skid_reg;
  logic    out_valid;
  logic    skid_valid;
  logic    in_xfer;
  logic    out_xfer;
  logic    advance;
  logic [VAL_W-1:0] read_now;

  assign s_tready = !skid_valid;
  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = out_valid && m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_reg};

  // remaining count as seen by a read; zero while idle
  assign read_now = counting ? VAL_W'(remaining_count) : '0;

  // next state and result for the item at the slave port
  always_comb begin
    remaining_count_next = remaining_count;
    counting_next        = counting;
    pulse_enable_next    = pulse_enable;
    last_command_next    = last_command;
    reload_value_next    = reload_value;
    level_store_next     = level_store;
    prescale_phase_next  = prescale_phase;
    res                  = '0;
    advance              = 1'b0;

    case (s_tuser)
      REQ_TICK: begin
        if (counting) begin
          // half-rate: count only when the phase wraps back to zero
          advance = double_resolution ? prescale_phase : 1'b1;
          if (double_resolution) begin
            prescale_phase_next = ~prescale_phase;
          end
          if (advance) begin
            if (remaining_count <= COUNT_BITS'(1)) begin
              remaining_count_next = '0;
              counting_next        = 1'b0;
              if (pulse_enable) begin
                if (int_enabled && !int_active) begin
                  res.irq_request = 1'b1;
                  res.irq_level   = level_store;
                end
                // periodic mode restarts from the reload value
                if (int_enabled && last_command == CMD_LOAD_RELOAD &&
                    reload_value != '0) begin
                  remaining_count_next = reload_value;
                  counting_next        = 1'b1;
                  prescale_phase_next  = 1'b0;
                end
              end
            end else begin
              remaining_count_next = remaining_count - COUNT_BITS'(1);
            end
          end
        end
      end
      REQ_CMD: begin
        last_command_next = command;
        unique case (command)
          CMD_STOP: begin
            counting_next     = 1'b0;
            reload_value_next = '0;
            pulse_enable_next = 1'b0;
          end
          CMD_LOAD: begin
            remaining_count_next = (cnt_in == '0) ? COUNT_BITS'(DEFAULT_COUNT) : cnt_in;
            counting_next        = 1'b1;
            prescale_phase_next  = 1'b0;
            pulse_enable_next    = 1'b1;
            reload_value_next    = '0;
          end
          CMD_LOAD_RELOAD: begin
            remaining_count_next = cnt_in;
            counting_next        = 1'b1;
            prescale_phase_next  = 1'b0;
            pulse_enable_next    = 1'b1;
            reload_value_next    = cnt_in;
          end
          CMD_READ: begin
            res.read_data     = read_now;
            pulse_enable_next = 1'b1;
          end
          CMD_READ_STOP: begin
            res.read_data     = read_now;
            counting_next     = 1'b0;
            pulse_enable_next = 1'b0;
          end
          CMD_READ_LOAD: begin
            res.read_data        = read_now;
            remaining_count_next = cnt_in;
            counting_next        = 1'b1;
            prescale_phase_next  = 1'b0;
            pulse_enable_next    = 1'b1;
            reload_value_next    = '0;
          end
          default: ;
        endcase
      end
      REQ_SETUP: begin
        level_store_next = int_level;
        if (setup_enable) begin
          pulse_enable_next = 1'b1;
        end else begin
          counting_next     = 1'b0;
          pulse_enable_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      double_resolution <= 1'b0;
    end else if (cfg_wr_en) begin
      double_resolution <= cfg_wr_data;
    end
  end

  // timer state update on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_count <= '0;
      counting        <= 1'b0;
      pulse_enable    <= 1'b0;
      last_command    <= '0;
      reload_value    <= '0;
      level_store     <= RESET_LEVEL;
      prescale_phase  <= 1'b0;
    end else if (in_xfer) begin
      remaining_count <= remaining_count_next;
      counting        <= counting_next;
      pulse_enable    <= pulse_enable_next;
      last_command    <= last_command_next;
      reload_value    <= reload_value_next;
      level_store     <= level_store_next;
      prescale_phase  <= prescale_phase_next;
    end
  end

  // output register with skid entry: skid fills only when the output
  // register is held by a stalled master
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_xfer) begin
        out_valid  <= skid_valid || in_xfer;
        skid_valid <= 1'b0;
      end else if (in_xfer) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_xfer) begin
      out_reg <= skid_valid ? skid_reg : res;
    end
    if (in_xfer && out_valid && !out_xfer) begin
      skid_reg <= res;
    end
  end

`ifndef SYNTHESIS
  // skid entry is only ever occupied behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // a held skid entry is not lost while the master stalls
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !m_tready |=> skid_valid)
    else $error("skid entry dropped during stall");

  // no interrupt level without a request
  a_level_needs_irq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[31] |-> m_tdata[38:32] == '0)
    else $error("irq level set without irq request");

  // timer comes out of reset idle with the reset level
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !counting && level_store == RESET_LEVEL)
    else $error("timer state not cleared by reset");
`endif

endmodule

// ===== dv/tb_interval_down_timer.sv =====
`timescale 1ns / 100ps

module tb_interval_down_timer;
  import idt_pkg::*;

  // Request kind 3 has no meaning in the block; it only yields an empty result
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  // Cycles without any transfer before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RANDOM_PER_PHASE = 125;

  // One slave-side item, unpacked
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [CMD_W-1:0] command;
    logic [VAL_W-1:0] count_value;
    logic             setup_enable;
    logic [LVL_W-1:0] int_level;
    logic             int_enabled;
    logic             int_active;
  } timer_item_t;

  // ---------------------------------------------------------------------------
  // DUT connections
  // ---------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_wr_data = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // tdata, low bit up: command, count_value, setup_enable, int_level,
  // int_enabled, int_active, zero pad
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // tuser: req_type
  logic [REQ_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  // tdata, low bit up: read_data, irq_request, irq_level, zero pad
  logic [OUT_DATA_W-1:0] m_tdata;

  interval_down_timer DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  // ---------------------------------------------------------------------------
  // Testbench state
  // ---------------------------------------------------------------------------
  timer_item_t pending_items[$];   // filled by the stimulus process
  result_t     exp_results[$];     // predicted results, oldest first
  timer_item_t cur_item;           // item currently offered on the slave side
  result_t     want;
  bit          item_taken = 1'b0;  // set at the edge that accepted cur_item
  bit          gaps_on = 1'b1;     // random idling enabled for this phase
  int unsigned send_gap = 0;
  int unsigned rx_stall = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  int unsigned n_queued = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_irqs = 0;
  int unsigned n_reads = 0;
  bit          saw_dbl0 = 1'b0;
  bit          saw_dbl1 = 1'b0;

  // Predicted timer state
  logic [VAL_W-1:0] remaining_cnt;
  logic [VAL_W-1:0] reload_cnt;
  logic             running;
  logic             pulse_en;
  logic             prescale;
  logic             dbl_res;
  logic [CMD_W-1:0] last_cmd;
  logic [LVL_W-1:0] irq_lvl_store;

  logic [CMD_W-1:0] known_cmds [6] = '{CMD_STOP, CMD_LOAD, CMD_LOAD_RELOAD,
                                       CMD_READ, CMD_READ_STOP, CMD_READ_LOAD};

  // ---------------------------------------------------------------------------
  // Timer prediction
  // ---------------------------------------------------------------------------
  function automatic void start_timer(logic [VAL_W-1:0] value);
    remaining_cnt = value;
    running       = 1'b1;
    prescale      = 1'b0;
    pulse_en      = 1'b1;
  endfunction

  function automatic result_t predict_timer_result(timer_item_t it);
    result_t r;
    logic    advance;
    r = '0;
    case (it.req_type)
      REQ_TICK: begin
        if (running) begin
          advance = 1'b1;
          // half rate: only the tick that brings the phase back to 0 counts
          if (dbl_res) begin
            prescale = ~prescale;
            advance  = !prescale;
          end
          if (advance) begin
            if (remaining_cnt <= 1) begin
              // expiry; a loaded zero behaves like one
              remaining_cnt = '0;
              running       = 1'b0;
              if (pulse_en) begin
                if (it.int_enabled && !it.int_active) begin
                  r.irq_request = 1'b1;
                  r.irq_level   = irq_lvl_store;
                end
                if (it.int_enabled && last_cmd == CMD_LOAD_RELOAD && reload_cnt != 0) begin
                  remaining_cnt = reload_cnt;
                  running       = 1'b1;
                  prescale      = 1'b0;
                end
              end
            end else begin
              remaining_cnt = remaining_cnt - 1'b1;
            end
          end
        end
      end
      REQ_CMD: begin
        last_cmd = it.command;
        case (it.command)
          CMD_STOP: begin
            running    = 1'b0;
            reload_cnt = '0;
            pulse_en   = 1'b0;
          end
          CMD_LOAD: begin
            start_timer(it.count_value == 0 ? VAL_W'(DEFAULT_COUNT) : it.count_value);
            reload_cnt = '0;
          end
          CMD_LOAD_RELOAD: begin
            start_timer(it.count_value);
            reload_cnt = it.count_value;
          end
          CMD_READ: begin
            r.read_data = running ? remaining_cnt : '0;
            pulse_en    = 1'b1;
          end
          CMD_READ_STOP: begin
            r.read_data = running ? remaining_cnt : '0;
            running     = 1'b0;
            pulse_en    = 1'b0;
          end
          CMD_READ_LOAD: begin
            // zero stays zero here, unlike the plain load
            r.read_data = running ? remaining_cnt : '0;
            start_timer(it.count_value);
            reload_cnt = '0;
          end
          default: ;
        endcase
      end
      REQ_SETUP: begin
        irq_lvl_store = it.int_level;
        if (it.setup_enable) begin
          pulse_en = 1'b1;
        end else begin
          running  = 1'b0;
          pulse_en = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    forever #2 clk = ~clk;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Slave-side driver: changes at the falling edge, fed from pending_items
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || item_taken)) begin
      item_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        s_tdata  <= {7'b0, cur_item.int_active, cur_item.int_enabled, cur_item.int_level,
                     cur_item.setup_enable, cur_item.count_value, cur_item.command};
        s_tuser  <= cur_item.req_type;
        s_tvalid <= 1'b1;
        if (gaps_on && $urandom_range(0, 99) < 30) send_gap = gap_len();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Master-side backpressure
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      rx_stall--;
      m_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 99) < 20) begin
      rx_stall = gap_len() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor, scoreboard and watchdog: sample at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (exp_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result 0x%h with nothing expected", $realtime, m_tdata);
        end else begin
          want = exp_results.pop_front();
          if (m_tdata[30:0] !== want.read_data || m_tdata[31] !== want.irq_request ||
              m_tdata[38:32] !== want.irq_level) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: result %0d: got read %0d irq %0b lvl 0x%h, %s %0d %0b 0x%h",
                       $realtime, n_results, m_tdata[30:0], m_tdata[31], m_tdata[38:32],
                       "expected read/irq/lvl", want.read_data, want.irq_request,
                       want.irq_level);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = predict_timer_result(cur_item);
        if (want.irq_request) n_irqs++;
        if (want.read_data != 0) n_reads++;
        exp_results.push_back(want);
        item_taken = 1'b1;
        n_items++;
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                   idle_cycles, exp_results.size());
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(logic [REQ_W-1:0] req, logic [CMD_W-1:0] c, logic [VAL_W-1:0] v,
                           logic en, logic [LVL_W-1:0] lvl, logic ie, logic ia);
    timer_item_t it;
    it = '{req_type: req, command: c, count_value: v, setup_enable: en,
           int_level: lvl, int_enabled: ie, int_active: ia};
    pending_items.push_back(it);
    n_queued++;
  endtask

  // Unused fields of each kind get random content
  task automatic tick_item(logic ie, logic ia);
    push_item(REQ_TICK, CMD_W'($urandom()), VAL_W'($urandom()), 1'($urandom_range(0, 1)),
              LVL_W'($urandom()), ie, ia);
  endtask

  task automatic cmd_item(logic [CMD_W-1:0] c, logic [VAL_W-1:0] v);
    push_item(REQ_CMD, c, v, 1'($urandom_range(0, 1)), LVL_W'($urandom()),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic setup_item(logic en, logic [LVL_W-1:0] lvl);
    push_item(REQ_SETUP, CMD_W'($urandom()), VAL_W'($urandom()), en, lvl,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Small counts so that expiries happen often; now and then the full range
  function automatic logic [VAL_W-1:0] rand_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return VAL_W'($urandom_range(0, 6));
    else if (r < 85) return VAL_W'($urandom_range(0, 40));
    else return VAL_W'($urandom());
  endfunction

  // Mostly load-then-tick sequences with reads mixed in, plus random noise
  task automatic add_random_items(int unsigned n);
    int unsigned target;
    int unsigned r;
    logic [CMD_W-1:0] c;
    target = n_queued + n;
    while (n_queued < target) begin
      if ($urandom_range(0, 99) < 65) begin
        if ($urandom_range(0, 99) < 15)
          setup_item($urandom_range(0, 99) < 85, LVL_W'($urandom()));
        c = known_cmds[$urandom_range(1, 2)];
        if ($urandom_range(0, 2) == 0) c = CMD_READ_LOAD;
        cmd_item(c, rand_count());
        repeat ($urandom_range(1, 12)) begin
          r = $urandom_range(0, 99);
          if (r < 15) cmd_item(known_cmds[$urandom_range(3, 5)], rand_count());
          else if (r < 18) cmd_item(CMD_STOP, VAL_W'($urandom()));
          else tick_item($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 20);
        end
      end else begin
        r = $urandom_range(0, 99);
        c = (r < 70) ? known_cmds[$urandom_range(0, 5)] : CMD_W'($urandom());
        push_item(REQ_W'($urandom_range(0, 3)), c, rand_count(), 1'($urandom_range(0, 1)),
                  LVL_W'($urandom()), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Hold off until every item is sent and every result has come back
  task automatic wait_until_drained();
    while (pending_items.size() != 0 || s_tvalid || exp_results.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Config writes happen only while the block is idle
  task automatic write_resolution(logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    dbl_res = v;
    if (v) saw_dbl1 = 1'b1;
    else saw_dbl0 = 1'b1;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    remaining_cnt = '0;
    reload_cnt    = '0;
    running       = 1'b0;
    pulse_en      = 1'b0;
    prescale      = 1'b0;
    dbl_res       = 1'b0;
    last_cmd      = '0;
    irq_lvl_store = RESET_LEVEL;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Phase 0: full resolution, directed corner cases
    write_resolution(1'b0);
    cmd_item(CMD_READ, '0);                 // read while idle
    tick_item(1'b1, 1'b0);                  // tick while idle
    push_item(REQ_UNUSED, '1, '1, 1'b1, '1, 1'b1, 1'b1);
    cmd_item(8'h00, '1);                    // unknown codes
    cmd_item(8'hff, '0);
    setup_item(1'b1, 7'h7f);
    cmd_item(CMD_LOAD, '0);                 // zero loads the default count
    cmd_item(CMD_READ, '0);
    cmd_item(CMD_READ_STOP, '0);
    cmd_item(CMD_LOAD, 31'd3);
    repeat (3) tick_item(1'b1, 1'b0);       // expiry with interrupt
    setup_item(1'b1, 7'h00);
    cmd_item(CMD_LOAD_RELOAD, 31'd2);
    repeat (2) tick_item(1'b1, 1'b0);       // expiry and reload
    repeat (2) tick_item(1'b1, 1'b1);       // level busy: reload, no request
    repeat (2) tick_item(1'b0, 1'b0);       // disabled: no reload
    cmd_item(CMD_READ_LOAD, '0);            // zero count expires next tick
    tick_item(1'b1, 1'b0);
    cmd_item(CMD_LOAD_RELOAD, '1);
    cmd_item(CMD_READ_LOAD, '1);            // widest count read back
    cmd_item(CMD_STOP, '0);
    cmd_item(CMD_LOAD, 31'd1);
    setup_item(1'b0, 7'h55);                // cancel
    tick_item(1'b1, 1'b0);
    wait_until_drained();

    // Phase 1: half resolution, directed then random
    write_resolution(1'b1);
    setup_item(1'b1, 7'h2a);
    cmd_item(CMD_LOAD, 31'd2);
    tick_item(1'b1, 1'b0);
    cmd_item(CMD_READ, '0);
    repeat (3) tick_item(1'b1, 1'b0);
    cmd_item(CMD_LOAD_RELOAD, '0);          // zero with reload: one-shot
    repeat (2) tick_item(1'b1, 1'b0);
    add_random_items(RANDOM_PER_PHASE);
    wait_until_drained();

    // Phase 2: full resolution, no idling on either side
    gaps_on = 1'b0;
    write_resolution(1'b0);
    add_random_items(RANDOM_PER_PHASE);
    wait_until_drained();

    // Phase 3: half resolution with idling
    gaps_on = 1'b1;
    write_resolution(1'b1);
    add_random_items(RANDOM_PER_PHASE);
    wait_until_drained();

    // Phase 4: back to full resolution
    write_resolution(1'b0);
    add_random_items(RANDOM_PER_PHASE);
    wait_until_drained();
    repeat (5) @(posedge clk);

    if (exp_results.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", exp_results.size());
    end
    $display("Run covered %0d items and %0d results: %0d interrupt requests, %0d nonzero reads.",
             n_items, n_results, n_irqs, n_reads);
    $display("Resolution settings exercised: single %0b, double %0b; %0d mismatches.",
             saw_dbl0, saw_dbl1, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/idt_pkg.sv
rtl/interval_down_timer.sv
dv/tb_interval_down_timer.sv
